/* rtl/core/rssi_tri_pkg.sv */
package rssi_tri_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int RSSI_BITS = 7;
   localparam int RSSI_TOP = 99;
   localparam int DIST_BITS = 17;
   localparam int DIST_SQ_BITS = 33;
   localparam int POS_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ANCHOR_A_X = 3'd0,
      REG_ANCHOR_A_Y = 3'd1,
      REG_ANCHOR_B_X = 3'd2,
      REG_ANCHOR_B_Y = 3'd3,
      REG_ANCHOR_C_X = 3'd4,
      REG_ANCHOR_C_Y = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COLLINEAR = 2'd1,
      STATUS_NO_Y_DIV  = 2'd2
   } status_type;

   // floor(10^(r/20)) for r = 0..99
   localparam logic [DIST_BITS-1:0] DIST_TABLE [0:RSSI_TOP] = '{
      17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd2, 17'd2, 17'd2,
      17'd3, 17'd3, 17'd3, 17'd4, 17'd5, 17'd5, 17'd6, 17'd7, 17'd7, 17'd8,
      17'd10, 17'd11, 17'd12, 17'd14, 17'd15, 17'd17, 17'd19, 17'd22, 17'd25, 17'd28,
      17'd31, 17'd35, 17'd39, 17'd44, 17'd50, 17'd56, 17'd63, 17'd70, 17'd79, 17'd89,
      17'd100, 17'd112, 17'd125, 17'd141, 17'd158, 17'd177, 17'd199, 17'd223,
      17'd251, 17'd281,
      17'd316, 17'd354, 17'd398, 17'd446, 17'd501, 17'd562, 17'd630, 17'd707,
      17'd794, 17'd891,
      17'd1000, 17'd1122, 17'd1258, 17'd1412, 17'd1584, 17'd1778, 17'd1995, 17'd2238,
      17'd2511, 17'd2818,
      17'd3162, 17'd3548, 17'd3981, 17'd4466, 17'd5011, 17'd5623, 17'd6309, 17'd7079,
      17'd7943, 17'd8912,
      17'd10000, 17'd11220, 17'd12589, 17'd14125, 17'd15848, 17'd17782, 17'd19952,
      17'd22387, 17'd25118, 17'd28183,
      17'd31622, 17'd35481, 17'd39810, 17'd44668, 17'd50118, 17'd56234, 17'd63095,
      17'd70794, 17'd79432, 17'd89125
   };

   function automatic logic [DIST_BITS-1:0] dist_of(input logic [RSSI_BITS-1:0] rssi);
      logic [RSSI_BITS-1:0] r;
      begin
         r = (rssi > RSSI_BITS'(RSSI_TOP)) ? RSSI_BITS'(RSSI_TOP) : rssi;
         return DIST_TABLE[r];
      end
   endfunction

endpackage

/* rtl/core/rssi_trilateration_unit.sv */
// Three-anchor 2-D position solver. Each item carries three RSSI magnitudes; the block
// turns them into distances, solves against the six anchor coordinates held in the csr
// registers and returns pos_x / pos_y in signed Q24.8 (saturated) plus a status code.
// One item can be accepted every cycle while no result waits; each result passes through
// five stages of lookup, squaring, halving, products and sign split, one
// divider setup stage, the two 32-step restoring dividers running side by side (one
// quotient bit per stage) and the output register. A result that waits stalls the whole
// pipeline. Anchor writes reach the solver through the registered anchor-only terms.
module rssi_trilateration_unit #(
   parameter int COORD_BITS = rssi_tri_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rssi_first [6:0], rssi_second [13:7], rssi_third [20:14]
   input  logic [23:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pos_x [31:0], pos_y [63:32], solve_status [65:64]
   output logic [71:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [rssi_tri_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);

   localparam int CB = COORD_BITS;
   localparam int DB = rssi_tri_pkg::DIST_BITS;
   localparam int QB = rssi_tri_pkg::DIST_SQ_BITS;
   localparam int PB = rssi_tri_pkg::POS_BITS;
   localparam int RB = rssi_tri_pkg::RSSI_BITS;
   localparam int SW = ((2 * CB > QB) ? 2 * CB : QB) + 3;
   localparam int XW = CB + 1;
   localparam int DW = 2 * CB + 3;
   localparam int PW = SW + XW;
   localparam int NW = PW + 1 + rssi_tri_pkg::FRAC_BITS;
   localparam int CW = (NW > DW + PB) ? NW : DW + PB;
   localparam int RW = DW + 1;

   typedef struct packed {
      logic          valid;
      logic [RW-1:0] rem_x;
      logic [RW-1:0] rem_y;
      logic [PB-1:0] low_x;
      logic [PB-1:0] low_y;
      logic [PB-1:0] q_x;
      logic [PB-1:0] q_y;
      logic          sat_x;
      logic          sat_y;
      logic          neg_x;
      logic          neg_y;
   } div_stage_type;

   // anchor registers
   logic [CB-1:0] anchor_ff [0:5];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) anchor_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rssi_tri_pkg::REG_ANCHOR_A_X: anchor_ff[0] <= csr_data;
            rssi_tri_pkg::REG_ANCHOR_A_Y: anchor_ff[1] <= csr_data;
            rssi_tri_pkg::REG_ANCHOR_B_X: anchor_ff[2] <= csr_data;
            rssi_tri_pkg::REG_ANCHOR_B_Y: anchor_ff[3] <= csr_data;
            rssi_tri_pkg::REG_ANCHOR_C_X: anchor_ff[4] <= csr_data;
            rssi_tri_pkg::REG_ANCHOR_C_Y: anchor_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // anchor-only terms, recomputed every cycle
   logic signed [XW-1:0] xd_in, yd_in, wd_in, td_in;
   logic signed [XW-1:0] xd_ff, yd_ff, wd_ff, td_ff;
   logic signed [SW-1:0] kab_in, kac_in, kab_ff, kac_ff;
   logic [2*CB-1:0]      csq [0:5];
   logic signed [DW-1:0] d_in, d_ff;
   logic [DW-1:0]        dmag_in, dmag_ff;
   logic                 dneg_ff, dzero_ff, tzero_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) csq[i] = anchor_ff[i] * anchor_ff[i];
      xd_in = $signed({1'b0, anchor_ff[0]}) - $signed({1'b0, anchor_ff[2]});
      yd_in = $signed({1'b0, anchor_ff[1]}) - $signed({1'b0, anchor_ff[3]});
      wd_in = $signed({1'b0, anchor_ff[0]}) - $signed({1'b0, anchor_ff[4]});
      td_in = $signed({1'b0, anchor_ff[1]}) - $signed({1'b0, anchor_ff[5]});
      kab_in = $signed(SW'(csq[0])) + $signed(SW'(csq[1]))
             - $signed(SW'(csq[2])) - $signed(SW'(csq[3]));
      kac_in = $signed(SW'(csq[0])) + $signed(SW'(csq[1]))
             - $signed(SW'(csq[4])) - $signed(SW'(csq[5]));
      d_in = DW'(td_ff) * DW'(xd_ff) - DW'(yd_ff) * DW'(wd_ff);
      dmag_in = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
   end

   always_ff @(posedge clock) begin
      xd_ff    <= xd_in;
      yd_ff    <= yd_in;
      wd_ff    <= wd_in;
      td_ff    <= td_in;
      kab_ff   <= kab_in;
      kac_ff   <= kac_in;
      d_ff     <= d_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= d_ff[DW-1];
      dzero_ff <= (d_ff == '0);
      tzero_ff <= (td_ff == '0);
   end

   // pipeline
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [DB-1:0] da_ff, db_ff, dc_ff;
   logic [QB-1:0] sqa_ff, sqb_ff, sqc_ff;
   logic signed [SW-1:0] sum_ab, sum_ac, a_in, b_in, a_ff, b_ff;
   logic signed [PW-1:0] p_at_ff, p_yb_ff, p_xb_ff, p_wa_ff;
   logic signed [NW-1:0] nx, ny;
   logic [NW-1:0]        nx_mag_ff, ny_mag_ff;
   logic                 nx_neg_ff, ny_neg_ff;
   logic [CW-1:0]        dshift;

   div_stage_type dv_ff [0:PB];
   div_stage_type dv_in [0:PB];

   always_comb begin
      sum_ab = kab_ff - $signed(SW'(sqa_ff)) + $signed(SW'(sqb_ff));
      sum_ac = kac_ff - $signed(SW'(sqa_ff)) + $signed(SW'(sqc_ff));
      // halve toward zero
      a_in = (sum_ab + $signed(SW'(sum_ab[SW-1]))) >>> 1;
      b_in = (sum_ac + $signed(SW'(sum_ac[SW-1]))) >>> 1;
      nx = (NW'(p_at_ff) - NW'(p_yb_ff)) <<< rssi_tri_pkg::FRAC_BITS;
      ny = (NW'(p_xb_ff) - NW'(p_wa_ff)) <<< rssi_tri_pkg::FRAC_BITS;
      dshift = CW'(dmag_ff) << PB;

      dv_in[0].valid = v5_ff;
      dv_in[0].rem_x = RW'(nx_mag_ff >> PB);
      dv_in[0].rem_y = RW'(ny_mag_ff >> PB);
      dv_in[0].low_x = nx_mag_ff[PB-1:0];
      dv_in[0].low_y = ny_mag_ff[PB-1:0];
      dv_in[0].q_x   = '0;
      dv_in[0].q_y   = '0;
      // quotient would not fit in 32 bits
      dv_in[0].sat_x = CW'(nx_mag_ff) >= dshift;
      dv_in[0].sat_y = CW'(ny_mag_ff) >= dshift;
      dv_in[0].neg_x = nx_neg_ff ^ dneg_ff;
      dv_in[0].neg_y = ny_neg_ff ^ dneg_ff;

      for (int j = 0; j < PB; j++) begin
         dv_in[j+1] = dv_ff[j];
         dv_in[j+1].rem_x = {dv_ff[j].rem_x[RW-2:0], dv_ff[j].low_x[PB-1]};
         dv_in[j+1].rem_y = {dv_ff[j].rem_y[RW-2:0], dv_ff[j].low_y[PB-1]};
         dv_in[j+1].low_x = dv_ff[j].low_x << 1;
         dv_in[j+1].low_y = dv_ff[j].low_y << 1;
         dv_in[j+1].q_x = {dv_ff[j].q_x[PB-2:0], dv_in[j+1].rem_x >= RW'(dmag_ff)};
         dv_in[j+1].q_y = {dv_ff[j].q_y[PB-2:0], dv_in[j+1].rem_y >= RW'(dmag_ff)};
         if (dv_in[j+1].q_x[0]) dv_in[j+1].rem_x = dv_in[j+1].rem_x - RW'(dmag_ff);
         if (dv_in[j+1].q_y[0]) dv_in[j+1].rem_y = dv_in[j+1].rem_y - RW'(dmag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int j = 0; j <= PB; j++) dv_ff[j].valid <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         for (int j = 0; j <= PB; j++) dv_ff[j] <= dv_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         da_ff <= rssi_tri_pkg::dist_of(req_tdata[RB-1:0]);
         db_ff <= rssi_tri_pkg::dist_of(req_tdata[2*RB-1:RB]);
         dc_ff <= rssi_tri_pkg::dist_of(req_tdata[3*RB-1:2*RB]);
         sqa_ff <= QB'(da_ff) * QB'(da_ff);
         sqb_ff <= QB'(db_ff) * QB'(db_ff);
         sqc_ff <= QB'(dc_ff) * QB'(dc_ff);
         a_ff <= a_in;
         b_ff <= b_in;
         p_at_ff <= PW'(a_ff) * PW'(td_ff);
         p_yb_ff <= PW'(yd_ff) * PW'(b_ff);
         p_xb_ff <= PW'(xd_ff) * PW'(b_ff);
         p_wa_ff <= PW'(wd_ff) * PW'(a_ff);
         nx_neg_ff <= nx[NW-1];
         ny_neg_ff <= ny[NW-1];
         nx_mag_ff <= nx[NW-1] ? NW'(-nx) : NW'(nx);
         ny_mag_ff <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      end
   end

   // saturate to 32-bit signed and pick status
   localparam logic [PB-1:0] MIN_MAG = {1'b1, {(PB-1){1'b0}}};

   function automatic logic [PB-1:0] sat_pos(input logic [PB-1:0] q, input logic sat,
                                             input logic neg);
      begin
         if (neg) begin
            if (sat || q > MIN_MAG) return MIN_MAG;
            else return PB'(-q);
         end else begin
            if (sat || q >= MIN_MAG) return ~MIN_MAG;
            else return q;
         end
      end
   endfunction

   logic [PB-1:0] pos_x_in, pos_y_in, pos_x_ff, pos_y_ff;
   logic [1:0]    status_in, status_ff;

   always_comb begin
      pos_x_in  = sat_pos(dv_ff[PB].q_x, dv_ff[PB].sat_x, dv_ff[PB].neg_x);
      pos_y_in  = sat_pos(dv_ff[PB].q_y, dv_ff[PB].sat_y, dv_ff[PB].neg_y);
      status_in = rssi_tri_pkg::STATUS_OK;
      if (dzero_ff) begin
         status_in = rssi_tri_pkg::STATUS_COLLINEAR;
         pos_x_in  = '0;
         pos_y_in  = '0;
      end else if (tzero_ff) begin
         status_in = rssi_tri_pkg::STATUS_NO_Y_DIV;
         pos_y_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[PB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tdata = {6'b0, status_ff, pos_y_ff, pos_x_ff};

endmodule

/* bench/rssi_trilateration_unit_tb.sv */
`timescale 1ns / 1ps

module rssi_trilateration_unit_tb;

   localparam int CB = rssi_tri_pkg::COORD_BITS_DEF;
   localparam int LATENCY = 39;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [31:0]       pos_x;
      logic signed [31:0]       pos_y;
      rssi_tri_pkg::status_type status;
   } position_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rssi_tri_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_data = '0;

   logic [CB-1:0] anchor_coord [0:5];
   position_type  expected_positions [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  sink_idling = 1'b1;
   bit  hold_sink = 1'b0;
   bit  source_idling = 1'b1;

   rssi_trilateration_unit u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // distances saturate above the top of the table
   function automatic longint distance_of(logic [6:0] rssi);
      return longint'(rssi_tri_pkg::DIST_TABLE[(rssi > 7'(rssi_tri_pkg::RSSI_TOP)) ?
                                               rssi_tri_pkg::RSSI_TOP : int'(rssi)]);
   endfunction

   function automatic logic [31:0] saturate_q(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic position_type solve_position(logic [6:0] r1, r2, r3);
      position_type p;
      longint da, db, dc, xa, ya, xb, yb, xc, yc, a, b, dx, dy, wx, ty, det;
      da = distance_of(r1);
      db = distance_of(r2);
      dc = distance_of(r3);
      xa = anchor_coord[0]; ya = anchor_coord[1];
      xb = anchor_coord[2]; yb = anchor_coord[3];
      xc = anchor_coord[4]; yc = anchor_coord[5];
      a = ((xa*xa - xb*xb) + (ya*ya - yb*yb) - (da*da - db*db)) / 2;
      b = ((xa*xa - xc*xc) + (ya*ya - yc*yc) - (da*da - dc*dc)) / 2;
      dx = xa - xb; dy = ya - yb; wx = xa - xc; ty = ya - yc;
      det = ty*dx - dy*wx;
      p.pos_x = '0;
      p.pos_y = '0;
      p.status = rssi_tri_pkg::STATUS_OK;
      if (det == 0) begin
         p.status = rssi_tri_pkg::STATUS_COLLINEAR;
      end else begin
         p.pos_x = saturate_q(((a*ty - dy*b) * 256) / det);
         if (ty == 0) p.status = rssi_tri_pkg::STATUS_NO_Y_DIV;
         else p.pos_y = saturate_q(((dx*b - wx*a) * 256) / det);
      end
      return p;
   endfunction

   task automatic write_anchor(rssi_tri_pkg::csr_index_type idx, logic [CB-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      anchor_coord[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_rssi(logic [6:0] r1, r2, r3);
      @(negedge clock);
      while (source_idling && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, r3, r2, r1};
      do @(posedge clock); while (!req_tready);
      expected_positions.push_back(solve_position(r1, r2, r3));
      // leave valid high; next call or drain lowers it
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_anchors(logic [CB-1:0] v0, v1, v2, v3, v4, v5);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_A_X, v0);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_A_Y, v1);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_B_X, v2);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_B_Y, v3);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_C_X, v4);
      write_anchor(rssi_tri_pkg::REG_ANCHOR_C_Y, v5);
      repeat (5) @(posedge clock);
   endtask

   task automatic random_rssi_items(int count);
      repeat (count) begin
         if ($urandom_range(9) == 0)
            send_rssi(7'($urandom), 7'($urandom), 7'($urandom));
         else
            send_rssi(7'($urandom_range(99)), 7'($urandom_range(99)),
                      7'($urandom_range(99)));
      end
   endtask

   task automatic test_directed();
      set_anchors(0, 0, 100, 0, 0, 100);
      send_rssi(0, 0, 0);
      send_rssi(99, 99, 99);
      send_rssi(127, 0, 127);
      send_rssi(0, 127, 99);
      send_rssi(40, 45, 50);
      send_rssi(60, 20, 80);
      wait_drained();
      // collinear anchors
      set_anchors(0, 0, 10, 10, 20, 20);
      send_rssi(10, 20, 30);
      send_rssi(99, 0, 50);
      wait_drained();
      // y divisor zero: a and c share y
      set_anchors(0, 50, 100, 0, 200, 50);
      send_rssi(30, 40, 50);
      send_rssi(0, 99, 0);
      wait_drained();
      // extremes of the coordinate range, saturating outputs
      set_anchors(4095, 4095, 0, 4095, 4095, 4094);
      send_rssi(0, 99, 99);
      send_rssi(99, 0, 0);
      send_rssi(99, 99, 0);
      send_rssi(0, 0, 0);
      wait_drained();
      set_anchors(0, 0, 4095, 0, 1, 1);
      send_rssi(99, 0, 99);
      send_rssi(0, 99, 0);
      wait_drained();
   endtask

   task automatic test_random_anchors();
      repeat (6) begin
         set_anchors(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom), CB'($urandom));
         random_rssi_items(160);
         wait_drained();
         set_anchors(CB'($urandom_range(200)), CB'($urandom_range(200)),
                     CB'($urandom_range(200)), CB'($urandom_range(200)),
                     CB'($urandom_range(200)), CB'($urandom_range(200)));
         random_rssi_items(80);
         wait_drained();
      end
   endtask

   task automatic test_back_pressure();
      set_anchors(10, 20, 3000, 40, 500, 3900);
      hold_sink = 1'b1;
      random_rssi_items(120);
      hold_sink = 1'b0;
      wait_drained();
   endtask

   task automatic test_full_rate();
      source_idling = 1'b0;
      sink_idling = 1'b0;
      set_anchors(1234, 77, 4000, 2500, 64, 3333);
      random_rssi_items(150);
      source_idling = 1'b1;
      sink_idling = 1'b1;
      wait_drained();
   endtask

   // receiver ready, with optional long hold-off
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_sink) begin
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(negedge clock);
            hold_sink = 1'b0;
         end
         rsp_tready <= !(sink_idling && $urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin
      position_type exp_pos;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_positions.size() == 0) begin
            $error("result with no expectation: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_pos = expected_positions.pop_front();
            if (rsp_tdata[31:0] !== exp_pos.pos_x) begin
               $error("pos_x expected %0d actual %0d", exp_pos.pos_x,
                      $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[63:32] !== exp_pos.pos_y) begin
               $error("pos_y expected %0d actual %0d", exp_pos.pos_y,
                      $signed(rsp_tdata[63:32]));
               error_count++;
            end
            if (rsp_tdata[65:64] !== exp_pos.status) begin
               $error("solve_status expected %0d actual %0d", exp_pos.status,
                      rsp_tdata[65:64]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 6; i++) anchor_coord[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset anchors are all zero, so everything is collinear
      send_rssi(50, 60, 70);
      wait_drained();
      test_directed();
      test_back_pressure();
      test_full_rate();
      test_random_anchors();
      if (error_count == 0 && expected_positions.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
